// File: rtl/range_sum_segment_tree_defines.svh
// Assertion macros used by the range-sum tree RTL.
// Each check takes a label, the clock, the reset, a condition and a consequence.
`ifndef RANGE_SUM_SEGMENT_TREE_DEFINES_SVH
`define RANGE_SUM_SEGMENT_TREE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequence must hold in the same cycle as the condition.
`define RSST_ASSERT_IMP(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("range sum tree check failed");

// The consequence must hold in the cycle after the condition.
`define RSST_ASSERT_NXT(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("range sum tree check failed");

`else

`define RSST_ASSERT_IMP(lbl, clk, rst, cond, cons)
`define RSST_ASSERT_NXT(lbl, clk, rst, cond, cons)

`endif

`endif

// File: rtl/rsst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsst_pkg;

  // Array size and derived widths.
  localparam int ELEMENT_COUNT = 1024;
  localparam int IDX_W         = 10;
  localparam int NODE_DEPTH    = 2 * ELEMENT_COUNT;
  localparam int ADDR_W        = IDX_W + 1;
  localparam int HEAP_W        = ADDR_W + 1;
  localparam int DATA_W        = 32;

  // Operation codes.
  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_S_LEAF_RD,
    ST_S_LEAF_WR,
    ST_S_RD,
    ST_S_WR,
    ST_Q_STEP,
    ST_Q_DONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/range_sum_segment_tree.sv
`timescale 1ns / 1ps
`default_nettype none
`include "range_sum_segment_tree_defines.svh"

// Range-sum segment tree over 1024 signed 32-bit elements, held in one
// 2048 x 32 node memory (heap order, leaves hold the elements) with a
// registered read. After reset a clearing pass writes zero to every node, one
// per cycle, and no request is taken until it ends. Requests are handled one
// at a time. A set request reads and writes the leaf, then reads and writes
// each of the ten nodes above the leaf, and ends when it sees that the root
// is done. A query walks the tree bottom-up, doing one memory read or one
// level step per cycle and stopping once it sees that the range has closed.
// A range covers at most two nodes on each of the nine lowest levels. The
// query then hands the sum to the output register, waiting while that
// register holds an earlier sum that is stalled; an empty range goes
// straight to this hand-over. A finished sum sits in an output register,
// so the next request can start while the sum waits to be taken.
module range_sum_segment_tree (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output      logic                        req_stall,
  input  wire logic                        func,
  input  wire logic [rsst_pkg::IDX_W-1:0]  position,
  input  wire logic [rsst_pkg::IDX_W-1:0]  range_last,
  input  wire logic signed [rsst_pkg::DATA_W-1:0] new_value,
  output      logic                        rsp_valid,
  input  wire logic                        rsp_stall,
  output      logic signed [rsst_pkg::DATA_W-1:0] range_total
);

  import rsst_pkg::*;

  // Node memory and its registered read data.
  logic [DATA_W-1:0] node_mem [NODE_DEPTH];
  logic [DATA_W-1:0] rd_data;

  logic              mem_re;
  logic              mem_we;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  // Sequencer registers.
  state_t            state, state_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic [ADDR_W-1:0] hn, hn_next;
  logic [HEAP_W-1:0] ql, ql_next;
  logic [HEAP_W-1:0] qr, qr_next;
  logic [DATA_W-1:0] val, val_next;
  logic [DATA_W-1:0] delta, delta_next;
  logic [DATA_W-1:0] acc, acc_next;
  logic              rd_pend, rd_pend_next;

  // Output register.
  logic              rsp_load;
  logic              out_free;

  assign req_stall = (state != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // Synchronous node memory: one write and one read port address per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= node_mem[rd_addr];
    end
  end

  // Next state, memory control and datapath updates.
  // Each set request finishes its writes before the next request is taken,
  // so a read never meets a pending write to the same node.
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    hn_next       = hn;
    ql_next       = ql;
    qr_next       = qr;
    val_next      = val;
    delta_next    = delta;
    acc_next      = rd_pend ? acc + rd_data : acc;
    rd_pend_next  = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = '0;
    wr_addr       = '0;
    wr_data       = '0;
    rsp_load      = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        mem_we        = 1'b1;
        wr_addr       = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(NODE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_valid) begin
          hn_next  = {1'b0, position} + ADDR_W'(ELEMENT_COUNT);
          ql_next  = {2'b00, position} + HEAP_W'(ELEMENT_COUNT);
          qr_next  = {2'b00, range_last} + HEAP_W'(ELEMENT_COUNT + 1);
          val_next = new_value;
          acc_next = '0;
          if (func == FUNC_SET) begin
            state_next = ST_S_LEAF_RD;
          end else begin
            state_next = ST_Q_STEP;
          end
        end
      end

      // Read the old element held in the leaf.
      ST_S_LEAF_RD: begin
        mem_re     = 1'b1;
        rd_addr    = hn - 1'b1;
        state_next = ST_S_LEAF_WR;
      end

      // Store the new element and keep the difference for the ancestors.
      ST_S_LEAF_WR: begin
        mem_we     = 1'b1;
        wr_addr    = hn - 1'b1;
        wr_data    = val;
        delta_next = val - rd_data;
        hn_next    = hn >> 1;
        state_next = ST_S_RD;
      end

      ST_S_RD: begin
        if (hn == '0) begin
          state_next = ST_IDLE;
        end else begin
          mem_re     = 1'b1;
          rd_addr    = hn - 1'b1;
          state_next = ST_S_WR;
        end
      end

      ST_S_WR: begin
        mem_we     = 1'b1;
        wr_addr    = hn - 1'b1;
        wr_data    = rd_data + delta;
        hn_next    = hn >> 1;
        state_next = ST_S_RD;
      end

      // Bottom-up walk over the half-open heap range [ql, qr).
      ST_Q_STEP: begin
        if (ql >= qr) begin
          state_next = ST_Q_DONE;
        end else if (ql[0]) begin
          mem_re       = 1'b1;
          rd_addr      = ADDR_W'(ql - 1'b1);
          rd_pend_next = 1'b1;
          ql_next      = ql + 1'b1;
        end else if (qr[0]) begin
          mem_re       = 1'b1;
          rd_addr      = ADDR_W'(qr - HEAP_W'(2));
          rd_pend_next = 1'b1;
          qr_next      = qr - 1'b1;
        end else begin
          ql_next = ql >> 1;
          qr_next = qr >> 1;
        end
      end

      // Let the last read land and the output register be free, then hand the sum to it.
      ST_Q_DONE: begin
        if (!rd_pend && out_free) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      rd_pend  <= rd_pend_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    hn    <= hn_next;
    ql    <= ql_next;
    qr    <= qr_next;
    val   <= val_next;
    delta <= delta_next;
    acc   <= acc_next;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      range_total <= acc;
    end
  end

  // The node memory is never read and written in the same cycle.
  `RSST_ASSERT_IMP(a_no_rw_overlap, clk, rst, mem_we, !mem_re)

  // Pending reads only occur while a query is in progress.
  `RSST_ASSERT_IMP(a_pend_in_query, clk, rst, rd_pend,
                   (state == ST_Q_STEP) || (state == ST_Q_DONE))

  // A loaded sum appears on the output in the next cycle.
  `RSST_ASSERT_NXT(a_load_shows, clk, rst, rsp_load,
                   rsp_valid && (range_total == $past(acc)))

endmodule

`default_nettype wire

// File: tb/tb_range_sum_segment_tree.sv
`timescale 1ns / 1ps

module tb_range_sum_segment_tree;
  import rsst_pkg::*;

  typedef struct {
    logic                     func;
    logic [IDX_W-1:0]         position;
    logic [IDX_W-1:0]         range_last;
    logic signed [DATA_W-1:0] new_value;
    bit                       hold_for_drain;
  } tree_req_t;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_RUNS} stall_mode_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic                     func = FUNC_SET;
  logic [IDX_W-1:0]         position = '0;
  logic [IDX_W-1:0]         range_last = '0;
  logic signed [DATA_W-1:0] new_value = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic signed [DATA_W-1:0] range_total;

  // Requests waiting to be driven, and sums owed by the block.
  tree_req_t                pending_reqs[$];
  logic signed [DATA_W-1:0] owed_totals[$];

  // Shadow copy of the element array.
  logic signed [DATA_W-1:0] element_values [0:ELEMENT_COUNT-1];

  int          queries_sent = 0;
  int          totals_received = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mismatch_count = 0;

  range_sum_segment_tree u_top (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .func       (func),
    .position   (position),
    .range_last (range_last),
    .new_value  (new_value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .range_total(range_total)
  );

  always #2 clk = ~clk;

  // Wrapping sum of the shadow elements over an inclusive range.
  function automatic logic signed [DATA_W-1:0] range_sum(input logic [IDX_W-1:0] first,
                                                         input logic [IDX_W-1:0] last);
    logic [DATA_W-1:0] acc;
    int                i;
    acc = '0;
    if (first > last) return '0;
    for (i = first; i <= last; i++) acc = acc + element_values[i];
    return acc;
  endfunction

  function automatic void queue_req(input logic f, input int first, input int last,
                                    input logic [DATA_W-1:0] value, input bit hold);
    tree_req_t r;
    r.func           = f;
    r.position       = first[IDX_W-1:0];
    r.range_last     = last[IDX_W-1:0];
    r.new_value      = value;
    r.hold_for_drain = hold;
    pending_reqs.push_back(r);
  endfunction

  // Set values lean on the wrap points now and then.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Set positions mostly land in a few hot windows so queries see real data.
  function automatic int pick_index();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 31);
      1:       return $urandom_range(992, 1023);
      2:       return $urandom_range(496, 527);
      default: return $urandom_range(0, ELEMENT_COUNT - 1);
    endcase
  endfunction

  function automatic void queue_random_query(input bit hold);
    int a;
    int b;
    int sel;
    a   = $urandom_range(0, ELEMENT_COUNT - 1);
    b   = $urandom_range(0, ELEMENT_COUNT - 1);
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      a = 0;
      b = ELEMENT_COUNT - 1;
    end else if (sel < 14) begin
      // Empty range: start past the end.
      if (a == b) a = (a == 0) ? 1 : a;
      if (a < b) begin
        int t;
        t = a;
        a = b;
        b = t;
      end
      if (a == b) b = a - 1;
    end else if (sel < 24) begin
      b = a;
    end else if (sel < 60) begin
      b = a + $urandom_range(0, 15);
      if (b > ELEMENT_COUNT - 1) b = ELEMENT_COUNT - 1;
    end else if (a > b) begin
      int t;
      t = a;
      a = b;
      b = t;
    end
    queue_req(FUNC_QUERY, a, b, $urandom, hold);
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin : drive_proc
    tree_req_t r;
    int        owed;
    bit        taken;
    if (rst) begin
      req_valid    <= 1'b0;
      queries_sent <= 0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else begin
      taken = req_valid && !req_stall;
      owed  = queries_sent + ((taken && func == FUNC_QUERY) ? 1 : 0) - totals_received;
      if (taken && func == FUNC_QUERY) queries_sent <= queries_sent + 1;
      if (!req_valid || taken) begin
        if (gap_left != 0) begin
          req_valid <= 1'b0;
          gap_left  <= gap_left - 1;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].hold_for_drain && owed != 0)) begin
          r = pending_reqs.pop_front();
          req_valid  <= 1'b1;
          func       <= r.func;
          position   <= r.position;
          range_last <= r.range_last;
          new_value  <= r.new_value;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 45);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall pattern: stretches of no stall, random stall and long stall runs.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
      stall_mode <= STALL_NONE;
    end else if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 300);
      rsp_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        STALL_NONE:  rsp_stall <= 1'b0;
        STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
        STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 8);
        default:     rsp_stall <= ((stall_left % 16) < 11);
      endcase
    end
  end

  // Result checker and shadow update. Results are checked before the
  // request of the same edge is applied, since a result never belongs to it.
  always @(posedge clk) begin : check_proc
    logic signed [DATA_W-1:0] want;
    int                       k;
    if (rst) begin
      totals_received <= 0;
      for (k = 0; k < ELEMENT_COUNT; k++) element_values[k] = '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        totals_received <= totals_received + 1;
        if (owed_totals.size() == 0) begin
          mismatch_count++;
          $display("%0t: range_total expected none, actual %0d", $time, range_total);
        end else begin
          want = owed_totals.pop_front();
          if (range_total !== want) begin
            mismatch_count++;
            $display("%0t: range_total expected %0d, actual %0d", $time, want, range_total);
          end
        end
      end
      if (req_valid && !req_stall) begin
        if (func == FUNC_SET) element_values[position] = new_value;
        else owed_totals.push_back(range_sum(position, range_last));
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stim_proc
    int n;
    // Extremes, wraparound, empty and single-element ranges.
    queue_req(FUNC_QUERY, 0, ELEMENT_COUNT - 1, 32'h1234_5678, 1'b0);
    queue_req(FUNC_SET, 0, 1023, 32'h7fff_ffff, 1'b0);
    queue_req(FUNC_SET, 1023, 0, 32'h8000_0000, 1'b0);
    queue_req(FUNC_SET, 512, 7, 32'hffff_ffff, 1'b0);
    queue_req(FUNC_SET, 511, 300, 32'h0000_0001, 1'b0);
    queue_req(FUNC_QUERY, 0, ELEMENT_COUNT - 1, 32'hffff_ffff, 1'b0);
    queue_req(FUNC_QUERY, 0, 0, 32'h0, 1'b0);
    queue_req(FUNC_QUERY, 1023, 1023, 32'h0, 1'b0);
    queue_req(FUNC_QUERY, 1023, 0, 32'h7fff_ffff, 1'b0);
    queue_req(FUNC_QUERY, 511, 512, 32'h8000_0000, 1'b0);
    queue_req(FUNC_SET, 1, 1023, 32'h7fff_ffff, 1'b0);
    queue_req(FUNC_QUERY, 0, 1, 32'h0, 1'b0);
    queue_req(FUNC_SET, 0, 0, 32'h0000_0000, 1'b0);
    queue_req(FUNC_QUERY, 0, 1, 32'h0, 1'b0);
    queue_req(FUNC_QUERY, 5, 4, 32'h0, 1'b0);
    queue_req(FUNC_QUERY, 0, 511, 32'h0, 1'b0);
    queue_req(FUNC_QUERY, 512, 1023, 32'h0, 1'b0);
    queue_req(FUNC_SET, 1023, 511, 32'h7fff_ffff, 1'b0);
    queue_req(FUNC_QUERY, 1000, 1023, 32'h0, 1'b0);
    // The sender holds this query back until every owed sum has come.
    queue_req(FUNC_QUERY, 300, 700, 32'h0, 1'b1);
    queue_req(FUNC_SET, 700, 1023, 32'h8000_0000, 1'b0);
    queue_req(FUNC_QUERY, 0, 1023, 32'h0, 1'b0);

    // Random mix of sets and queries, with an occasional drain.
    for (n = 0; n < 1630; n++) begin
      if ($urandom_range(0, 1) == 0)
        queue_req(FUNC_SET, pick_index(), $urandom_range(0, 1023), pick_value(),
                  (n % 400) == 399);
      else
        queue_random_query((n % 400) == 399);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (owed_totals.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("range_sum_segment_tree: match");
    end else begin
      $display("range_sum_segment_tree: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung block.
  initial begin
    #20000000;
    $display("range_sum_segment_tree: mismatch");
    $finish;
  end

endmodule
